FILE: design/esd_pkg.sv
// Shared types, character codes and decode helpers for the escape sequence decoder.
// No dependencies; used by esd_core, esd_out_buf and escape_sequence_decoder.
package esd_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 13;
  localparam int NIB_W  = 4;

  // Largest value the length / limit fields can hold
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LB     = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LN     = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LR     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LV     = 8'h76;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
  localparam logic [CHAR_W-1:0] HEX_TEN   = 8'd10;

  // Raw bytes produced by the single-character escapes
  localparam logic [CHAR_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] BYTE_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] BYTE_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] BYTE_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] BYTE_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] BYTE_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] BYTE_CR  = 8'h0D;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX1   = 2'd2,
    MODE_HEX2   = 2'd3
  } mode_t;

  // One result item
  typedef struct packed {
    logic [CHAR_W-1:0] out_byte;
    logic              byte_valid;
    logic              done_res;
    logic              error;
    logic [LEN_W-1:0]  decoded_length;
  } res_t;

  // Hex digit lookup: {valid, value}
  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] value;
  } hex_t;

  // Escape lookup: {valid, byte}
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] value;
  } esc_t;

  function automatic hex_t hex_digit(input logic [CHAR_W-1:0] c);
    hex_t h;
    logic [CHAR_W-1:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      h.valid = 1'b1;
      h.value = d[NIB_W-1:0];
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + HEX_TEN;
      h.valid = 1'b1;
      h.value = d[NIB_W-1:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + HEX_TEN;
      h.valid = 1'b1;
      h.value = d[NIB_W-1:0];
    end
    return h;
  endfunction

  function automatic esc_t escape_byte(input logic [CHAR_W-1:0] c);
    esc_t e;
    e.valid = 1'b1;
    case (c)
      CH_BSLASH: e.value = CH_BSLASH;
      CH_ZERO:   e.value = BYTE_NUL;
      CH_LA:     e.value = BYTE_BEL;
      CH_LB:     e.value = BYTE_BS;
      CH_LF:     e.value = BYTE_FF;
      CH_LN:     e.value = BYTE_LF;
      CH_LR:     e.value = BYTE_CR;
      CH_LT:     e.value = BYTE_TAB;
      CH_LV:     e.value = BYTE_VT;
      default: begin
        e.valid = 1'b0;
        e.value = '0;
      end
    endcase
    return e;
  endfunction

endpackage

FILE: design/esd_core.sv
// Decode core: limit register, per-string state and the combinational escape decoder.
// Depends on esd_pkg.
module esd_core #(
  parameter int MAX_OUTPUT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [esd_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        fire,      // input request taken this cycle
  input  logic [esd_pkg::CHAR_W-1:0]  in_char,
  input  logic                        is_last,
  output logic                        emit,      // this request yields a result
  output esd_pkg::res_t               res
);
  import esd_pkg::*;

  // Effective cap; out_limit never exceeds LEN_MAX, so a larger cap acts as LEN_MAX
  localparam int CAP_INT = (MAX_OUTPUT > LEN_MAX) ? LEN_MAX : MAX_OUTPUT;
  localparam logic [LEN_W-1:0] LIM_CAP = LEN_W'(CAP_INT);

  logic [LEN_W-1:0] out_limit_r;
  mode_t            mode_r, mode_nxt;
  logic [NIB_W-1:0] nibble_r, nibble_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             failed_r, failed_nxt;

  logic [LEN_W-1:0] limit;
  logic             room;
  hex_t             hx;
  esc_t             es;
  logic             have;
  logic [CHAR_W-1:0] byte_val;

  assign limit = (out_limit_r < LIM_CAP) ? out_limit_r : LIM_CAP;
  assign room  = count_r < limit;
  assign hx    = hex_digit(in_char);
  assign es    = escape_byte(in_char);

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    nibble_nxt = nibble_r;
    failed_nxt = failed_r;
    if (!failed_r) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (room && in_char == CH_BSLASH) begin
            if (is_last) failed_nxt = 1'b1;
            else         mode_nxt   = MODE_ESC;
          end
        end
        MODE_ESC: begin
          if (in_char == CH_X) begin
            if (is_last) failed_nxt = 1'b1;
            else         mode_nxt   = MODE_HEX1;
          end else if (es.valid) begin
            mode_nxt = MODE_NORMAL;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        MODE_HEX1: begin
          if (!hx.valid || is_last) begin
            failed_nxt = 1'b1;
          end else begin
            nibble_nxt = hx.value;
            mode_nxt   = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          if (hx.valid) mode_nxt   = MODE_NORMAL;
          else          failed_nxt = 1'b1;
        end
        default: mode_nxt = MODE_NORMAL;
      endcase
    end
  end

  // Outputs: decoded byte for this character
  always_comb begin
    have     = 1'b0;
    byte_val = '0;
    if (!failed_r) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (room && in_char != CH_BSLASH) begin
            have     = 1'b1;
            byte_val = in_char;
          end
        end
        MODE_ESC: begin
          if (in_char != CH_X && es.valid) begin
            have     = 1'b1;
            byte_val = es.value;
          end
        end
        MODE_HEX2: begin
          if (hx.valid) begin
            have     = 1'b1;
            byte_val = {nibble_r, hx.value};
          end
        end
        default: have = 1'b0;
      endcase
    end
  end

  assign count_nxt = count_r + LEN_W'(have);

  // Result item
  assign emit               = have | is_last;
  assign res.out_byte       = byte_val;
  assign res.byte_valid     = have;
  assign res.done_res       = is_last;
  assign res.error          = is_last & failed_nxt;
  assign res.decoded_length = (is_last && !failed_nxt) ? count_nxt : '0;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= LEN_W'(4096);
    end else if (cfg_wr_en) begin
      out_limit_r <= cfg_wr_data;
    end
  end

  // String state; the last character clears it for the next string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      nibble_r <= '0;
      count_r  <= '0;
      failed_r <= 1'b0;
    end else if (fire) begin
      if (is_last) begin
        mode_r   <= MODE_NORMAL;
        nibble_r <= '0;
        count_r  <= '0;
        failed_r <= 1'b0;
      end else begin
        mode_r   <= mode_nxt;
        nibble_r <= nibble_nxt;
        count_r  <= count_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

endmodule

FILE: design/esd_out_buf.sv
// Result register: holds one result item until the downstream side takes it.
// Depends on esd_pkg.
module esd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,       // load a new result
  input  esd_pkg::res_t push_res,
  output logic          can_load,   // register free or emptying this cycle
  output logic          out_valid,
  input  logic          out_ready,
  output esd_pkg::res_t out_res
);
  import esd_pkg::*;

  logic out_valid_r;
  res_t res_r;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= push_res;
    end
  end

endmodule

FILE: design/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: stream ports, decode core and result register.
// Depends on esd_pkg, esd_core and esd_out_buf.
//
//  Channel  | Dir | Handshake           | Content
//  ---------+-----+---------------------+----------------------------------------------
//  in_*     | in  | in_tvalid/in_tready | one character, tlast on the last one
//  out_*    | out | out_tvalid/tready   | decoded byte and/or closing length/error
//  cfg_*    | in  | cfg_wr_en           | out_limit, most decoded bytes per string
//
// One character per cycle while the result register can load; each result shows in the following cycle.
// Sustained rate is set by the single result register: a character is taken
// whenever that register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous) sets the limit to 4096 and clears the string.
// A stalled output holds its result; characters producing no result still wait.
module escape_sequence_decoder #(
  parameter int MAX_OUTPUT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,   // out_limit
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] in_char
  input  logic        in_tlast,      // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [7:0] out_byte, [8] error, [21:9] decoded_length
  output logic        out_tuser,     // byte_valid
  output logic        out_tlast      // done_res
);
  import esd_pkg::*;

  logic fire;
  logic emit;
  logic can_load;
  res_t core_res;
  res_t buf_res;

  assign in_tready = can_load;
  assign fire      = in_tvalid & in_tready;

  esd_core #(
    .MAX_OUTPUT (MAX_OUTPUT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .in_char     (in_tdata),
    .is_last     (in_tlast),
    .emit        (emit),
    .res         (core_res)
  );

  esd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire & emit),
    .push_res  (core_res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (buf_res)
  );

  // Pack result fields onto the stream
  assign out_tdata = {2'b00, buf_res.decoded_length, buf_res.error, buf_res.out_byte};
  assign out_tuser = buf_res.byte_valid;
  assign out_tlast = buf_res.done_res;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for escape_sequence_decoder: streams escaped strings, predicts
// every decoded byte and closing result, and compares them. Depends on esd_pkg and the RTL.
module tb_top;
  import esd_pkg::*;

  localparam int MAX_BYTES = 4096;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_UNKNOWN_ESC,
    FLAW_LONE_BSLASH,
    FLAW_SHORT_HEX,
    FLAW_BAD_HEX
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] in_char
  logic        in_tlast = 1'b0;  // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;   // [7:0] out_byte, [8] error, [21:9] decoded_length
  logic        out_tuser;   // byte_valid
  logic        out_tlast;   // done_res

  // stimulus and scoreboard
  char_req_t   char_queue[$];
  logic [7:0]  str_buf[$];
  res_t        expected_decodes[$];
  int          chars_planned = 0;
  int          results_seen = 0;
  int          fail_cnt = 0;
  logic        in_fire = 1'b0;

  // predictor state
  mode_t       dec_mode = MODE_NORMAL;
  logic [3:0]  hi_nib = '0;
  logic [12:0] n_bytes = '0;
  logic        bad = 1'b0;
  logic [12:0] limit_q = 13'd4096;

  // sender and receiver pacing
  int          burst_left = 0;
  int          gap_left = 0;
  int          seg_left = 0;
  int          ready_pct = 100;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  escape_sequence_decoder #(
    .MAX_OUTPUT(MAX_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // {valid, value} of a hex digit in either case
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, c[3:0]};
    if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Predict the result (if any) of one accepted character
  function automatic void decode_char(input logic [7:0] ch, input logic last);
    res_t        r;
    logic        have;
    logic [7:0]  b;
    logic [4:0]  nib;
    logic [12:0] eff;
    have = 1'b0;
    b = '0;
    nib = nibble_of(ch);
    eff = (limit_q < 13'(MAX_BYTES)) ? limit_q : 13'(MAX_BYTES);
    if (!bad) begin
      case (dec_mode)
        MODE_NORMAL: begin
          // at the limit everything is dropped, backslashes too
          if (n_bytes < eff) begin
            if (ch == CH_BSLASH) begin
              if (last) bad = 1'b1;
              else dec_mode = MODE_ESC;
            end else begin
              have = 1'b1;
              b = ch;
            end
          end
        end
        MODE_ESC: begin
          have = 1'b1;
          dec_mode = MODE_NORMAL;
          case (ch)
            CH_BSLASH: b = CH_BSLASH;
            CH_ZERO:   b = BYTE_NUL;
            CH_LA:     b = BYTE_BEL;
            CH_LB:     b = BYTE_BS;
            CH_LF:     b = BYTE_FF;
            CH_LN:     b = BYTE_LF;
            CH_LR:     b = BYTE_CR;
            CH_LT:     b = BYTE_TAB;
            CH_LV:     b = BYTE_VT;
            CH_X: begin
              have = 1'b0;
              if (last) bad = 1'b1;
              else dec_mode = MODE_HEX1;
            end
            default: begin
              have = 1'b0;
              bad = 1'b1;
            end
          endcase
        end
        MODE_HEX1: begin
          if (!nib[4] || last) begin
            bad = 1'b1;
          end else begin
            hi_nib = nib[3:0];
            dec_mode = MODE_HEX2;
          end
        end
        default: begin
          if (!nib[4]) begin
            bad = 1'b1;
          end else begin
            have = 1'b1;
            b = {hi_nib, nib[3:0]};
            dec_mode = MODE_NORMAL;
          end
        end
      endcase
      if (have) n_bytes = n_bytes + 13'd1;
    end
    if (have || last) begin
      r.out_byte = have ? b : 8'd0;
      r.byte_valid = have;
      r.done_res = last;
      r.error = last && bad;
      r.decoded_length = (last && !bad) ? n_bytes : 13'd0;
      expected_decodes.push_back(r);
    end
    // a new string starts clean
    if (last) begin
      dec_mode = MODE_NORMAL;
      hi_nib = '0;
      n_bytes = '0;
      bad = 1'b0;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Result check first, then prediction of the request taken at this edge
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_decodes.size() == 0) begin
        $error("result with no request pending: tdata=%h tuser=%b tlast=%b",
               out_tdata, out_tuser, out_tlast);
        fail_cnt++;
      end else begin
        want = expected_decodes.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(out_tdata[7:0]));
        check_field("byte_valid", 32'(want.byte_valid), 32'(out_tuser));
        check_field("done_res", 32'(want.done_res), 32'(out_tlast));
        check_field("error", 32'(want.error), 32'(out_tdata[8]));
        check_field("decoded_length", 32'(want.decoded_length), 32'(out_tdata[21:9]));
      end
    end
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) decode_char(in_tdata, in_tlast);
  end

  // Sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    char_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (char_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        req = char_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= req.ch;
        in_tlast <= req.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: stretches with their own ready rate, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 250;
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 150);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 80;
          2: ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      seg_left--;
      out_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Move the buffered string to the request queue, flagging its last character
  function automatic void flush_string();
    char_req_t req;
    for (int i = 0; i < str_buf.size(); i++) begin
      req.ch = str_buf[i];
      req.last = (i == str_buf.size() - 1);
      char_queue.push_back(req);
      chars_planned++;
    end
    str_buf.delete();
  endfunction

  function automatic void add_text(input string t);
    for (int i = 0; i < t.len(); i++) str_buf.push_back(t[i]);
    flush_string();
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 8))
      0: return CH_BSLASH;
      1: return CH_ZERO;
      2: return CH_LA;
      3: return CH_LB;
      4: return CH_LF;
      5: return CH_LN;
      6: return CH_LR;
      7: return CH_LT;
      default: return CH_LV;
    endcase
  endfunction

  // Mostly well-formed strings; some hold a malformed escape, possibly followed by junk
  function automatic void add_random_string(input int max_units);
    flaw_t      flaw;
    int         units;
    logic [7:0] c;
    logic [4:0] nib;
    flaw = ($urandom_range(0, 99) < 15) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
    units = $urandom_range((flaw == FLAW_NONE) ? 1 : 0, max_units);
    for (int i = 0; i < units; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
          str_buf.push_back(c);
        end
        5, 6, 7: begin
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(pick_escape());
        end
        default: begin
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(CH_X);
          str_buf.push_back(rand_hex());
          str_buf.push_back(rand_hex());
        end
      endcase
    end
    case (flaw)
      FLAW_UNKNOWN_ESC: begin
        str_buf.push_back(CH_BSLASH);
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_BSLASH, CH_ZERO, CH_LA, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV,
                         CH_X});
        str_buf.push_back(c);
      end
      FLAW_LONE_BSLASH: str_buf.push_back(CH_BSLASH);
      FLAW_SHORT_HEX: begin
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(CH_X);
        if ($urandom_range(0, 1)) str_buf.push_back(rand_hex());
      end
      FLAW_BAD_HEX: begin
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(CH_X);
        if ($urandom_range(0, 1)) str_buf.push_back(rand_hex());
        do begin
          c = 8'($urandom_range(0, 255));
          nib = nibble_of(c);
        end while (nib[4]);
        str_buf.push_back(c);
      end
      default: ;
    endcase
    // junk after a mid-string fault, dropped by the block
    if (flaw == FLAW_UNKNOWN_ESC || flaw == FLAW_BAD_HEX)
      repeat ($urandom_range(0, 3)) str_buf.push_back(8'($urandom_range(0, 255)));
    flush_string();
  endfunction

  function automatic void add_random_chars(input int n_chars, input int max_units);
    int stop_at;
    stop_at = chars_planned + n_chars;
    while (chars_planned < stop_at) add_random_string(max_units);
  endfunction

  // Wait until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (char_queue.size() != 0 || (in_tvalid && !in_fire) || expected_decodes.size() != 0);
  endtask

  // Limit writes only happen with the block idle
  task automatic set_limit(input logic [12:0] lim);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    limit_q = lim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every escape, hex in both cases, char extremes, each malformed form
    set_limit(13'd4096);
    add_text("\\\\\\0\\a\\b\\f\\n\\r\\t\\v");
    add_text("\\xAf");
    str_buf.push_back(8'h00);
    flush_string();
    str_buf.push_back(8'hFF);
    flush_string();
    add_text("\\q");
    add_text("\\");
    add_text("\\x");
    add_text("\\x4");
    add_text("\\xg");
    add_random_chars(300, 8);

    // zero limit: nothing decoded, no error possible
    set_limit(13'd0);
    add_random_chars(80, 6);

    set_limit(13'd1);
    add_random_chars(100, 6);

    // largest register value, clipped to the build limit
    set_limit(13'h1FFF);
    add_random_chars(250, 10);

    set_limit(13'd3);
    add_random_chars(100, 8);

    set_limit(13'($urandom_range(2, 30)));
    add_random_chars(150, 16);

    set_limit(13'd4096);
    add_random_chars(100, 8);

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
